// File: src/ofip_pkg.sv
// Shared types, character codes and helpers for the face index parser.
// No dependencies; used by every module of the block.
`default_nettype none

package ofip_pkg;

    localparam int INDEX_BITS = 24;
    localparam int COUNT_BITS = 16;
    localparam int ACC_BITS   = 32;
    localparam int MUL_BITS   = ACC_BITS + 4;
    localparam int CHAR_BITS  = 8;
    localparam int MIN_REFS   = 3;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [MUL_BITS-1:0] INT_LIMIT = MUL_BITS'(32'h7FFF_FFFF);

    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_EOL  = 1'b1;

    localparam logic KIND_REF     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EXPECTED_INT = 2'd1,
        ST_UNDEFINED    = 2'd2,
        ST_INCOHERENT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_SPACE     = 3'd0,
        PH_VERT      = 3'd1,
        PH_TEX       = 3'd2,
        PH_NORM_ONLY = 3'd3,
        PH_TNORM     = 3'd4,
        PH_ERROR     = 3'd5
    } phase_t;

    typedef struct packed {
        logic                  func;
        logic [CHAR_BITS-1:0]  char_code;
        logic [INDEX_BITS-1:0] vertex_count;
        logic [INDEX_BITS-1:0] texture_count;
        logic [INDEX_BITS-1:0] normal_count;
    } item_t;

    typedef struct packed {
        logic                  kind;
        logic [INDEX_BITS-1:0] vertex_index;
        logic [INDEX_BITS-1:0] texture_index;
        logic [INDEX_BITS-1:0] normal_index;
        logic                  has_texture;
        logic                  has_normal;
        status_t               status;
        logic [COUNT_BITS-1:0] ref_count;
        logic                  last;
    } result_t;

    // Up to two results per item, already packed in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Values that do not fit the index width read as zero, which fails range check.
    function automatic logic [INDEX_BITS-1:0] clip_index(input logic [ACC_BITS-1:0] value);
        logic [ACC_BITS-1:0] upper;
        upper = value >> INDEX_BITS;
        return (upper != '0) ? '0 : value[INDEX_BITS-1:0];
    endfunction

    function automatic logic out_of_range(input logic [INDEX_BITS-1:0] idx,
                                          input logic [INDEX_BITS-1:0] limit);
        return (idx == '0) || (idx > limit);
    endfunction

endpackage

`default_nettype wire

// File: src/ofip_parser.sv
// Face line parse state and per-character update logic.
// Depends on ofip_pkg; feeds ofip_result_fifo.
`default_nettype none

module ofip_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire ofip_pkg::item_t item,
    output ofip_pkg::push_t     push
);

    ofip_pkg::phase_t                     phase_reg, phase_next;
    logic [ofip_pkg::ACC_BITS-1:0]        acc_reg, acc_next;
    logic                                 digit_seen_reg, digit_seen_next;
    logic [ofip_pkg::INDEX_BITS-1:0]      held_vertex_reg, held_vertex_next;
    logic [ofip_pkg::INDEX_BITS-1:0]      held_texture_reg, held_texture_next;
    logic                                 first_has_texture_reg, first_has_texture_next;
    logic                                 first_has_normal_reg, first_has_normal_next;
    logic [ofip_pkg::COUNT_BITS-1:0]      refs_seen_reg, refs_seen_next;
    ofip_pkg::status_t                    error_code_reg, error_code_next;

    // reference completion
    logic                                 comp_active;
    logic [ofip_pkg::INDEX_BITS-1:0]      acc_clip;
    logic [ofip_pkg::INDEX_BITS-1:0]      cv, ct, cn;
    logic                                 cht, chn;
    logic                                 comp_fail;
    ofip_pkg::status_t                    comp_code;
    logic [ofip_pkg::COUNT_BITS-1:0]      refs_inc;
    ofip_pkg::result_t                    ref_res, sum_res;

    // character decode
    logic                                 is_space, is_digit, is_slash;
    logic [ofip_pkg::CHAR_BITS-1:0]       digit_diff;
    logic [ofip_pkg::ACC_BITS-1:0]        acc_base;
    logic [ofip_pkg::MUL_BITS-1:0]        acc_wide;

    logic                                 ref_valid, sum_valid;
    logic [ofip_pkg::COUNT_BITS-1:0]      refs_after;
    ofip_pkg::status_t                    err_after;

    always_comb
    begin
        is_space = (item.char_code == ofip_pkg::CH_SPACE) ||
                   ((item.char_code >= ofip_pkg::CH_TAB) && (item.char_code <= ofip_pkg::CH_CR));
        is_digit = (item.char_code >= ofip_pkg::CH_ZERO) && (item.char_code <= ofip_pkg::CH_NINE);
        is_slash = (item.char_code == ofip_pkg::CH_SLASH);
        digit_diff = item.char_code - ofip_pkg::CH_ZERO;
        acc_base = (phase_reg == ofip_pkg::PH_SPACE) ? '0 : acc_reg;
        // acc * 10 + digit
        acc_wide = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                   + ofip_pkg::MUL_BITS'(digit_diff);
    end

    always_comb
    begin
        acc_clip    = ofip_pkg::clip_index(acc_reg);
        comp_active = 1'b1;
        cv  = held_vertex_reg;
        ct  = '0;
        cn  = '0;
        cht = 1'b0;
        chn = 1'b0;
        unique case (phase_reg)
            ofip_pkg::PH_VERT:
            begin
                cv = acc_clip;
            end
            ofip_pkg::PH_TEX:
            begin
                cht = digit_seen_reg;
                ct  = acc_clip;
            end
            ofip_pkg::PH_NORM_ONLY:
            begin
                chn = digit_seen_reg;
                cn  = acc_clip;
            end
            ofip_pkg::PH_TNORM:
            begin
                cht = 1'b1;
                ct  = held_texture_reg;
                chn = digit_seen_reg;
                cn  = acc_clip;
            end
            default:
            begin
                comp_active = 1'b0;
            end
        endcase

        comp_fail = 1'b1;
        comp_code = ofip_pkg::ST_UNDEFINED;
        if (ofip_pkg::out_of_range(cv, item.vertex_count))
            comp_code = ofip_pkg::ST_UNDEFINED;
        else if ((refs_seen_reg != '0) &&
                 ((cht != first_has_texture_reg) || (chn != first_has_normal_reg)))
            comp_code = ofip_pkg::ST_INCOHERENT;
        else if (cht && ofip_pkg::out_of_range(ct, item.texture_count))
            comp_code = ofip_pkg::ST_UNDEFINED;
        else if (chn && ofip_pkg::out_of_range(cn, item.normal_count))
            comp_code = ofip_pkg::ST_UNDEFINED;
        else
            comp_fail = 1'b0;

        refs_inc = (refs_seen_reg == '1) ? refs_seen_reg : refs_seen_reg + 1'b1;

        ref_res               = '0;
        ref_res.kind          = ofip_pkg::KIND_REF;
        ref_res.vertex_index  = cv - 1'b1;
        ref_res.texture_index = cht ? ct - 1'b1 : '0;
        ref_res.normal_index  = chn ? cn - 1'b1 : '0;
        ref_res.has_texture   = cht;
        ref_res.has_normal    = chn;
        ref_res.status        = ofip_pkg::ST_OK;
    end

    always_comb
    begin
        phase_next             = phase_reg;
        acc_next               = acc_reg;
        digit_seen_next        = digit_seen_reg;
        held_vertex_next       = held_vertex_reg;
        held_texture_next      = held_texture_reg;
        first_has_texture_next = first_has_texture_reg;
        first_has_normal_next  = first_has_normal_reg;
        refs_seen_next         = refs_seen_reg;
        error_code_next        = error_code_reg;
        ref_valid              = 1'b0;
        sum_valid              = 1'b0;
        refs_after             = refs_seen_reg;
        err_after              = error_code_reg;

        if (fire)
        begin
            if (item.func == ofip_pkg::FUNC_EOL)
            begin
                // close any open reference, then summarize and clear the line
                if (comp_active)
                begin
                    if (comp_fail)
                        err_after = comp_code;
                    else
                    begin
                        refs_after = refs_inc;
                        ref_valid  = 1'b1;
                    end
                end
                sum_valid              = 1'b1;
                phase_next             = ofip_pkg::PH_SPACE;
                acc_next               = '0;
                digit_seen_next        = 1'b0;
                held_vertex_next       = '0;
                held_texture_next      = '0;
                first_has_texture_next = 1'b0;
                first_has_normal_next  = 1'b0;
                refs_seen_next         = '0;
                error_code_next        = ofip_pkg::ST_OK;
            end
            else if (phase_reg != ofip_pkg::PH_ERROR)
            begin
                if (is_space)
                begin
                    if (phase_reg != ofip_pkg::PH_SPACE)
                    begin
                        phase_next      = ofip_pkg::PH_SPACE;
                        acc_next        = '0;
                        digit_seen_next = 1'b0;
                        if (comp_fail)
                        begin
                            phase_next      = ofip_pkg::PH_ERROR;
                            error_code_next = comp_code;
                        end
                        else
                        begin
                            ref_valid      = 1'b1;
                            refs_seen_next = refs_inc;
                            if (refs_seen_reg == '0)
                            begin
                                first_has_texture_next = cht;
                                first_has_normal_next  = chn;
                            end
                        end
                    end
                end
                else if (is_digit)
                begin
                    if (acc_wide > ofip_pkg::INT_LIMIT)
                    begin
                        phase_next      = ofip_pkg::PH_ERROR;
                        error_code_next = ofip_pkg::ST_EXPECTED_INT;
                    end
                    else
                    begin
                        acc_next        = acc_wide[ofip_pkg::ACC_BITS-1:0];
                        digit_seen_next = 1'b1;
                        if (phase_reg == ofip_pkg::PH_SPACE)
                            phase_next = ofip_pkg::PH_VERT;
                    end
                end
                else if (is_slash && (phase_reg == ofip_pkg::PH_VERT))
                begin
                    held_vertex_next = acc_clip;
                    phase_next       = ofip_pkg::PH_TEX;
                    acc_next         = '0;
                    digit_seen_next  = 1'b0;
                end
                else if (is_slash && (phase_reg == ofip_pkg::PH_TEX))
                begin
                    if (digit_seen_reg)
                    begin
                        held_texture_next = acc_clip;
                        phase_next        = ofip_pkg::PH_TNORM;
                    end
                    else
                        phase_next = ofip_pkg::PH_NORM_ONLY;
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                end
                else
                begin
                    // stray byte, sign, or empty component
                    phase_next      = ofip_pkg::PH_ERROR;
                    error_code_next = ofip_pkg::ST_EXPECTED_INT;
                end
            end
        end

        sum_res           = '0;
        sum_res.kind      = ofip_pkg::KIND_SUMMARY;
        sum_res.status    = ((err_after == ofip_pkg::ST_OK) &&
                             (refs_after < ofip_pkg::COUNT_BITS'(ofip_pkg::MIN_REFS)))
                            ? ofip_pkg::ST_EXPECTED_INT : err_after;
        sum_res.ref_count = refs_after;
        sum_res.last      = 1'b1;

        push.count  = {1'b0, ref_valid} + {1'b0, sum_valid};
        push.first  = ref_valid ? ref_res : sum_res;
        push.second = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= ofip_pkg::PH_SPACE;
            acc_reg               <= '0;
            digit_seen_reg        <= 1'b0;
            held_vertex_reg       <= '0;
            held_texture_reg      <= '0;
            first_has_texture_reg <= 1'b0;
            first_has_normal_reg  <= 1'b0;
            refs_seen_reg         <= '0;
            error_code_reg        <= ofip_pkg::ST_OK;
        end
        else
        begin
            phase_reg             <= phase_next;
            acc_reg               <= acc_next;
            digit_seen_reg        <= digit_seen_next;
            held_vertex_reg       <= held_vertex_next;
            held_texture_reg      <= held_texture_next;
            first_has_texture_reg <= first_has_texture_next;
            first_has_normal_reg  <= first_has_normal_next;
            refs_seen_reg         <= refs_seen_next;
            error_code_reg        <= error_code_next;
        end
    end

endmodule

`default_nettype wire

// File: src/ofip_result_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one beat.
// Depends on ofip_pkg.
`default_nettype none

module ofip_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ofip_pkg::push_t   push,
    output logic                   room,
    output logic                   head_valid,
    input  wire logic              head_taken,
    output ofip_pkg::result_t      head
);

    localparam int PB = ofip_pkg::FIFO_PTR_BITS;

    ofip_pkg::result_t mem [ofip_pkg::FIFO_DEPTH];

    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PB:0]   count_reg, count_next;
    logic          pop;

    always_comb
    begin
        head_valid  = (count_reg != '0);
        head        = mem[rd_ptr_reg];
        // two free slots needed, since one item may yield two results
        room        = (count_reg <= (PB+1)'(ofip_pkg::FIFO_DEPTH - 2));
        pop         = head_valid && head_taken;
        wr_ptr_next = wr_ptr_reg + PB'(push.count);
        rd_ptr_next = rd_ptr_reg + PB'(pop);
        count_next  = count_reg + (PB+1)'(push.count) - (PB+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + 1'b1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/obj_face_index_parser_unit.sv
// Top level of the face line index parser: input register, parser, result queue.
// Depends on ofip_pkg, ofip_parser and ofip_result_fifo.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_stall | func, char_code, vertex/texture/normal_count
//  out     | out_valid/out_stall | kind, *_index, has_*, status, ref_count, last
//
// One beat per cycle in unless stalled; a beat is parsed once the queue has room.
// An end-of-line beat may yield two results (closing reference plus summary);
// the 4-entry result queue absorbs them: one beat per cycle while out_stall is low.
// in_stall rises only when the queue has fewer than two free slots.
// Reset clears the parse state to the start of a line and empties the queue.
`default_nettype none

module obj_face_index_parser_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               func,
    input  wire logic [ofip_pkg::CHAR_BITS-1:0]     char_code,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0]    vertex_count,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0]    texture_count,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0]    normal_count,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    kind,
    output logic [ofip_pkg::INDEX_BITS-1:0]         vertex_index,
    output logic [ofip_pkg::INDEX_BITS-1:0]         texture_index,
    output logic [ofip_pkg::INDEX_BITS-1:0]         normal_index,
    output logic                                    has_texture,
    output logic                                    has_normal,
    output logic [1:0]                              status,
    output logic [ofip_pkg::COUNT_BITS-1:0]         ref_count,
    output logic                                    last
);

    logic              item_valid_reg, item_valid_next;
    ofip_pkg::item_t   item_reg;
    logic              room;
    logic              fire;
    ofip_pkg::push_t   push;
    ofip_pkg::result_t head;

    always_comb
    begin
        fire            = item_valid_reg && room;
        in_stall        = item_valid_reg && !room;
        item_valid_next = in_stall ? item_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.func          <= func;
            item_reg.char_code     <= char_code;
            item_reg.vertex_count  <= vertex_count;
            item_reg.texture_count <= texture_count;
            item_reg.normal_count  <= normal_count;
        end
    end

    ofip_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    ofip_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (out_valid),
        .head_taken (!out_stall),
        .head       (head)
    );

    assign kind          = head.kind;
    assign vertex_index  = head.vertex_index;
    assign texture_index = head.texture_index;
    assign normal_index  = head.normal_index;
    assign has_texture   = head.has_texture;
    assign has_normal    = head.has_normal;
    assign status        = head.status;
    assign ref_count     = head.ref_count;
    assign last          = head.last;

endmodule

`default_nettype wire

// File: tb/obj_face_index_parser_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the face index parser: watches both channels, predicts every
// reference and line summary from the accepted beats and compares result beats.
// Depends on ofip_pkg.
module obj_face_index_parser_unit_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            func,
    input  wire logic [ofip_pkg::CHAR_BITS-1:0]  char_code,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0] vertex_count,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0] texture_count,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0] normal_count,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            kind,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0] vertex_index,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0] texture_index,
    input  wire logic [ofip_pkg::INDEX_BITS-1:0] normal_index,
    input  wire logic                            has_texture,
    input  wire logic                            has_normal,
    input  wire logic [1:0]                      status,
    input  wire logic [ofip_pkg::COUNT_BITS-1:0] ref_count,
    input  wire logic                            last,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   refs_checked,
    output int                                   lines_checked,
    output int                                   lines_failed
);
    import ofip_pkg::*;

    typedef logic [INDEX_BITS-1:0] index_t;

    // parse state of the line in progress
    phase_t                parse_phase;
    logic [ACC_BITS-1:0]   number_acc;
    logic                  have_digit;
    index_t                vert_hold;
    index_t                tex_hold;
    logic                  lead_has_tex;
    logic                  lead_has_norm;
    logic [COUNT_BITS-1:0] refs_taken;
    status_t               line_status;

    result_t face_results_due[$];
    int      mismatches;
    int      results_seen;
    int      refs_done;
    int      lines_done;
    int      lines_bad;

    function automatic index_t fit_index(input logic [ACC_BITS-1:0] value);
        return (value[ACC_BITS-1:INDEX_BITS] != '0) ? '0 : value[INDEX_BITS-1:0];
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("kind=%0d v=%0d t=%0d n=%0d ht=%0d hn=%0d st=%0d cnt=%0d last=%0d",
                         r.kind, r.vertex_index, r.texture_index, r.normal_index,
                         r.has_texture, r.has_normal, r.status, r.ref_count, r.last);
    endfunction

    task automatic clear_line;
        parse_phase   = PH_SPACE;
        number_acc    = '0;
        have_digit    = 1'b0;
        vert_hold     = '0;
        tex_hold      = '0;
        lead_has_tex  = 1'b0;
        lead_has_norm = 1'b0;
        refs_taken    = '0;
        line_status   = ST_OK;
    endtask

    task automatic abort_line(input status_t code);
        line_status = code;
        parse_phase = PH_ERROR;
    endtask

    task automatic close_reference(input index_t vc, input index_t tc, input index_t nc);
        index_t  acc_idx;
        index_t  v_idx;
        index_t  t_idx;
        index_t  n_idx;
        logic    with_tex;
        logic    with_norm;
        result_t r;
        acc_idx   = fit_index(number_acc);
        v_idx     = vert_hold;
        t_idx     = '0;
        n_idx     = '0;
        with_tex  = 1'b0;
        with_norm = 1'b0;
        case (parse_phase)
            PH_VERT:
                v_idx = acc_idx;
            PH_TEX:
                if (have_digit)
                begin
                    with_tex = 1'b1;
                    t_idx    = acc_idx;
                end
            PH_NORM_ONLY:
                if (have_digit)
                begin
                    with_norm = 1'b1;
                    n_idx     = acc_idx;
                end
            PH_TNORM:
            begin
                with_tex = 1'b1;
                t_idx    = tex_hold;
                if (have_digit)
                begin
                    with_norm = 1'b1;
                    n_idx     = acc_idx;
                end
            end
            default:
                return;
        endcase
        parse_phase = PH_SPACE;
        number_acc  = '0;
        have_digit  = 1'b0;

        // vertex range, then coherence with the first reference, then t and n ranges
        if (v_idx == '0 || v_idx > vc)
            abort_line(ST_UNDEFINED);
        else if (refs_taken != '0 &&
                 (with_tex != lead_has_tex || with_norm != lead_has_norm))
            abort_line(ST_INCOHERENT);
        else if (with_tex && (t_idx == '0 || t_idx > tc))
            abort_line(ST_UNDEFINED);
        else if (with_norm && (n_idx == '0 || n_idx > nc))
            abort_line(ST_UNDEFINED);
        else
        begin
            if (refs_taken == '0)
            begin
                lead_has_tex  = with_tex;
                lead_has_norm = with_norm;
            end
            if (refs_taken != '1)
                refs_taken++;
            r               = '0;
            r.kind          = KIND_REF;
            r.vertex_index  = v_idx - 1'b1;
            r.texture_index = with_tex ? t_idx - 1'b1 : '0;
            r.normal_index  = with_norm ? n_idx - 1'b1 : '0;
            r.has_texture   = with_tex;
            r.has_normal    = with_norm;
            r.status        = ST_OK;
            face_results_due.push_back(r);
        end
    endtask

    task automatic take_character(input logic [CHAR_BITS-1:0] c, input index_t vc,
                                  input index_t tc, input index_t nc);
        logic [MUL_BITS-1:0] grown;
        if (parse_phase == PH_ERROR)
            return;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
        begin
            if (parse_phase != PH_SPACE)
                close_reference(vc, tc, nc);
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (parse_phase == PH_SPACE)
            begin
                parse_phase = PH_VERT;
                number_acc  = '0;
            end
            grown = MUL_BITS'(number_acc) * 10 + MUL_BITS'(c - CH_ZERO);
            if (grown > INT_LIMIT)
                abort_line(ST_EXPECTED_INT);
            else
            begin
                number_acc = grown[ACC_BITS-1:0];
                have_digit = 1'b1;
            end
        end
        else if (c == CH_SLASH && parse_phase == PH_VERT)
        begin
            vert_hold   = fit_index(number_acc);
            parse_phase = PH_TEX;
            number_acc  = '0;
            have_digit  = 1'b0;
        end
        else if (c == CH_SLASH && parse_phase == PH_TEX)
        begin
            if (have_digit)
            begin
                tex_hold    = fit_index(number_acc);
                parse_phase = PH_TNORM;
            end
            else
                parse_phase = PH_NORM_ONLY;
            number_acc = '0;
            have_digit = 1'b0;
        end
        else
            abort_line(ST_EXPECTED_INT);
    endtask

    task automatic close_line(input index_t vc, input index_t tc, input index_t nc);
        result_t r;
        if (parse_phase != PH_SPACE && parse_phase != PH_ERROR)
            close_reference(vc, tc, nc);
        r           = '0;
        r.kind      = KIND_SUMMARY;
        r.status    = line_status;
        // fewer than three references with no other error still fails the line
        if (line_status == ST_OK && refs_taken < MIN_REFS)
            r.status = ST_EXPECTED_INT;
        r.ref_count = refs_taken;
        r.last      = 1'b1;
        face_results_due.push_back(r);
        clear_line();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t due;
        if (!rst_n)
        begin
            clear_line();
            face_results_due.delete();
            mismatches    = 0;
            results_seen  = 0;
            refs_done     = 0;
            lines_done    = 0;
            lines_bad     = 0;
            pending       <= 0;
            fail_count    <= 0;
            refs_checked  <= 0;
            lines_checked <= 0;
            lines_failed  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_EOL)
                    close_line(vertex_count, texture_count, normal_count);
                else
                    take_character(char_code, vertex_count, texture_count, normal_count);
            end
            if (out_valid && !out_stall)
            begin
                seen.kind          = kind;
                seen.vertex_index  = vertex_index;
                seen.texture_index = texture_index;
                seen.normal_index  = normal_index;
                seen.has_texture   = has_texture;
                seen.has_normal    = has_normal;
                seen.status        = status_t'(status);
                seen.ref_count     = ref_count;
                seen.last          = last;
                results_seen++;
                if (face_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat %0d with nothing expected: %s",
                                 $time, results_seen, describe(seen));
                end
                else
                begin
                    due = face_results_due.pop_front();
                    if (due.kind == KIND_SUMMARY)
                    begin
                        lines_done++;
                        if (due.status != ST_OK)
                            lines_bad++;
                    end
                    else
                        refs_done++;
                    if (seen.kind !== due.kind ||
                        seen.vertex_index !== due.vertex_index ||
                        seen.texture_index !== due.texture_index ||
                        seen.normal_index !== due.normal_index ||
                        seen.has_texture !== due.has_texture ||
                        seen.has_normal !== due.has_normal ||
                        seen.status !== due.status ||
                        seen.ref_count !== due.ref_count ||
                        seen.last !== due.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result beat %0d differs", $time, results_seen);
                            $display("    expected %s", describe(due));
                            $display("    actual   %s", describe(seen));
                        end
                    end
                end
            end
            pending       <= face_results_due.size();
            fail_count    <= mismatches;
            refs_checked  <= refs_done;
            lines_checked <= lines_done;
            lines_failed  <= lines_bad;
        end
    end

endmodule

// File: tb/obj_face_index_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the face index parser: clock, reset, face line stimulus and
// receiver stalls; prediction and comparison live in the checker module.
// Depends on ofip_pkg, obj_face_index_parser_unit and its checker.
module obj_face_index_parser_unit_tb;
    import ofip_pkg::*;

    localparam int ITEM_GOAL   = 1050;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef logic [INDEX_BITS-1:0] index_t;

    typedef enum int {
        FORM_V,
        FORM_VT,
        FORM_VN,
        FORM_VTN,
        FORM_V_SLASH,
        FORM_V_SLASH2,
        FORM_VT_SLASH
    } ref_form_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [CHAR_BITS-1:0]  char_code;
    index_t                vertex_count;
    index_t                texture_count;
    index_t                normal_count;
    logic                  out_valid;
    logic                  out_stall;
    logic                  kind;
    index_t                vertex_index;
    index_t                texture_index;
    index_t                normal_index;
    logic                  has_texture;
    logic                  has_normal;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] ref_count;
    logic                  last;

    int fail_count;
    int pending;
    int refs_checked;
    int lines_checked;
    int lines_failed;

    index_t     line_vc;
    index_t     line_tc;
    index_t     line_nc;
    byte unsigned line_text[$];
    int         beats_sent;
    int         lines_sent;
    int         burst_left;
    bit         steady;
    int         hold_requests;
    int         cycle_count;

    obj_face_index_parser_unit uut (.*);

    obj_face_index_parser_unit_checker face_check (.*);

    always #10 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("no completion after %0d cycles", cycle_count);
        $display("obj_face_index_parser_unit: mismatch");
        $finish;
    end

    // Receiver: switches between stall patterns; a request from the stimulus
    // side makes it hold off for a long stretch so the block backs up.
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_served;
        int          period;
        int          tick;
        out_stall   = 1'b0;
        mode        = STALL_NONE;
        mode_left   = 0;
        hold_served = 0;
        period      = 2;
        tick        = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 200);
                period    = $urandom_range(2, 5);
            end
            mode_left--;
            tick++;
            case (mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                default:      out_stall <= (tick % period == 0);
            endcase
        end
    end

    // One input beat; bursts of random length with random gaps unless steady.
    task automatic offer_beat(input logic beat_func, input logic [CHAR_BITS-1:0] beat_char);
        int gap;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(0, 4);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        in_valid      <= 1'b1;
        func          <= beat_func;
        char_code     <= beat_char;
        vertex_count  <= line_vc;
        texture_count <= line_tc;
        normal_count  <= line_nc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_text.push_back(s[i]);
    endtask

    task automatic play_line;
        while (line_text.size() != 0)
            offer_beat(FUNC_CHAR, line_text.pop_front());
        // char_code is a don't-care on the line end beat
        offer_beat(FUNC_EOL, CHAR_BITS'($urandom_range(0, 255)));
        lines_sent++;
    endtask

    task automatic add_blanks;
        repeat ($urandom_range(1, 2))
            line_text.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13))
                                                            : CH_SPACE);
    endtask

    function automatic index_t pick_count(input bit allow_zero);
        case ($urandom_range(0, 9))
            0:       return allow_zero ? '0 : index_t'(1);
            1:       return '1;
            2, 3:    return index_t'($urandom) | index_t'(!allow_zero);
            default: return index_t'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic add_number(input index_t count, input bit faulty);
        longint unsigned value;
        string           digits;
        value = (count == '0) ? 1 : $urandom_range(1, count);
        if (faulty && $urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 4))
                0: value = 0;
                1: value = longint'(count) + 1;
                2: value = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
                3: value = 64'h7FFF_FFFF + $urandom_range(0, 1);
                default: value = 64'h8000_0000 + $urandom;
            endcase
        end
        digits = $sformatf("%0d", value);
        if ($urandom_range(0, 19) == 0)
            digits = {"0", digits};
        load_text(digits);
    endtask

    // Mostly well-formed lines with random content; the rest carry bad
    // numbers, a reference of another shape, stray bytes or too few refs.
    task automatic build_random_line;
        bit        clean;
        int        refs;
        int        odd_one;
        ref_form_t lead_form;
        ref_form_t form;
        byte unsigned noise;
        clean     = ($urandom_range(0, 9) < 6);
        line_vc   = pick_count(!clean);
        line_tc   = pick_count(!clean);
        line_nc   = pick_count(!clean);
        refs      = (!clean && $urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 6);
        lead_form = ref_form_t'($urandom_range(0, 6));
        odd_one   = (!clean && $urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : -1;
        if ($urandom_range(0, 3) == 0)
            add_blanks();
        for (int r = 0; r < refs; r++)
        begin
            form = (r == odd_one) ? ref_form_t'($urandom_range(0, 6)) : lead_form;
            add_number(line_vc, !clean);
            case (form)
                FORM_VT:
                begin
                    line_text.push_back(CH_SLASH);
                    add_number(line_tc, !clean);
                end
                FORM_VN:
                begin
                    load_text("//");
                    add_number(line_nc, !clean);
                end
                FORM_VTN:
                begin
                    line_text.push_back(CH_SLASH);
                    add_number(line_tc, !clean);
                    line_text.push_back(CH_SLASH);
                    add_number(line_nc, !clean);
                end
                FORM_V_SLASH:
                    line_text.push_back(CH_SLASH);
                FORM_V_SLASH2:
                    load_text("//");
                FORM_VT_SLASH:
                begin
                    line_text.push_back(CH_SLASH);
                    add_number(line_tc, !clean);
                    line_text.push_back(CH_SLASH);
                end
                default:
                    ;
            endcase
            if (r != refs - 1 || $urandom_range(0, 1) == 1)
                add_blanks();
        end
        if (!clean && $urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       noise = $urandom_range(0, 255);
                1:       noise = CH_SLASH;
                2:       noise = "+";
                default: noise = "-";
            endcase
            line_text.insert($urandom_range(0, line_text.size()), noise);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_CHAR;
        char_code     = '0;
        vertex_count  = '0;
        texture_count = '0;
        normal_count  = '0;
        line_vc       = '0;
        line_tc       = '0;
        line_nc       = '0;
        beats_sent    = 0;
        lines_sent    = 0;
        burst_left    = 0;
        steady        = 1'b0;
        hold_requests = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain triangle with the largest vertex count
        line_vc = '1;
        load_text("1 2 3");
        play_line();
        // sign character
        load_text("-");
        play_line();
        // v/t/ closed by the line end, too few references
        line_vc = index_t'(1);
        line_tc = index_t'(2);
        load_text("1/2/");
        play_line();
        // zero index
        line_vc = index_t'(9);
        load_text("9 0");
        play_line();
        // empty component at reference start
        line_text.push_back(CH_SLASH);
        play_line();
        line_text.push_back(8'hFF);
        play_line();
        // empty line
        play_line();
        wait_for_results();

        while (beats_sent < ITEM_GOAL)
        begin
            steady = ($urandom_range(0, 4) == 0);
            build_random_line();
            if (lines_sent == 12)
                hold_requests++;
            play_line();
            if (lines_sent % 25 == 0)
                wait_for_results();
        end
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d beats on %0d face lines in %0d cycles.",
                 beats_sent, lines_sent, cycle_count);
        $display("Checked %0d references and %0d line summaries, %0d lines with errors.",
                 refs_checked, lines_checked, lines_failed);
        if (fail_count == 0)
            $display("obj_face_index_parser_unit: match");
        else
            $display("obj_face_index_parser_unit: mismatch");
        $finish;
    end

endmodule

// File: obj_face_index_parser_unit.f
src/ofip_pkg.sv
src/ofip_parser.sv
src/ofip_result_fifo.sv
src/obj_face_index_parser_unit.sv
tb/obj_face_index_parser_unit_checker.sv
tb/obj_face_index_parser_unit_tb.sv
